/* sv/multiset_count_table_top_defines.svh */
// Shared assertion macros for the counting table
`ifndef MULTISET_COUNT_TABLE_TOP_DEFINES_SVH
`define MULTISET_COUNT_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked only outside reset
`define MCT_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked only outside reset
`define MCT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* sv/mct_pkg.sv */
package mct_pkg;

	// Table geometry
	localparam int ENTRIES = 32;
	localparam int IDX_W   = $clog2(ENTRIES);

	// Field widths
	localparam int VALUE_W  = 8;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Operation codes
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INC     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DEC     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

	typedef struct packed {
		logic               opcode;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [COUNT_W-1:0]  count_after;
	} rsp_t;

	// One table slot as held in memory
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// Microcode addresses
	typedef logic [1:0] mc_addr_t;
	localparam mc_addr_t PC_IDLE   = 2'd0;
	localparam mc_addr_t PC_SCAN   = 2'd1;
	localparam mc_addr_t PC_DRAIN  = 2'd2;
	localparam mc_addr_t PC_UPDATE = 2'd3;

	// Jump conditions
	typedef enum logic [1:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NOT_START,
		COND_NOT_LAST
	} cond_t;

	// One control word
	typedef struct packed {
		cond_t    cond;
		mc_addr_t target;
		logic     load;
		logic     rd;
		logic     upd;
		logic     busy;
	} mc_word_t;

	// Datapath status back to the sequencer
	typedef struct packed {
		logic scan_last;
	} sts_t;

	// Control store
	function automatic mc_word_t mc_rom(input mc_addr_t pc);
		mc_word_t w;
		w = '{cond: COND_NEVER, target: PC_IDLE, load: 1'b0, rd: 1'b0,
			upd: 1'b0, busy: 1'b1};
		unique case (pc)
			PC_IDLE: begin
				w.cond   = COND_NOT_START;
				w.target = PC_IDLE;
				w.load   = 1'b1;
				w.busy   = 1'b0;
			end
			PC_SCAN: begin
				w.cond   = COND_NOT_LAST;
				w.target = PC_SCAN;
				w.rd     = 1'b1;
			end
			PC_DRAIN: begin
				w.cond = COND_NEVER;
			end
			PC_UPDATE: begin
				w.cond   = COND_ALWAYS;
				w.target = PC_IDLE;
				w.upd    = 1'b1;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

/* sv/multiset_count_table_top.sv */
// A new request is taken only in the idle step; the scan reads one slot
// a cycle from the single-port slot memory, then one drain and one update step.
// busy is low only in the idle step, which is also the strobe cycle of the last result.
// Reset (arst_n low) empties the table and returns the sequencer to idle at once.
// The receiver cannot stall: done marks each result for one cycle only; result holds until the next update.
module multiset_count_table_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mct_pkg::req_t  request,
	output logic           busy,
	output logic           done,
	output mct_pkg::rsp_t  result
);
	import mct_pkg::*;

	mc_word_t ctl;
	sts_t     sts;

	mct_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl)
	);

	mct_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.ctl     (ctl),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

	assign busy = ctl.busy;

endmodule

/* sv/mct_seq.sv */
module mct_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mct_pkg::sts_t     sts,
	output mct_pkg::mc_word_t ctl
);
	import mct_pkg::*;

	mc_addr_t pc_q;
	mc_addr_t pc_next;
	logic     take_jump;

	// Fetch the control word for this step
	assign ctl = mc_rom(pc_q);

	// Evaluate the jump condition
	always_comb begin
		unique case (ctl.cond)
			COND_NEVER:     take_jump = 1'b0;
			COND_ALWAYS:    take_jump = 1'b1;
			COND_NOT_START: take_jump = !start;
			COND_NOT_LAST:  take_jump = !sts.scan_last;
			default:        take_jump = 1'b1;
		endcase
		pc_next = take_jump ? ctl.target : mc_addr_t'(pc_q + 2'd1);
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

/* sv/mct_dp.sv */
`include "multiset_count_table_top_defines.svh"

module mct_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mct_pkg::req_t     request,
	input  mct_pkg::mc_word_t ctl,
	output mct_pkg::sts_t     sts,
	output logic              done,
	output mct_pkg::rsp_t     result
);
	import mct_pkg::*;

	// Slot storage and valid marks
	entry_t            mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	// Held request and scan trackers
	req_t               req_q;
	logic [IDX_W-1:0]   addr_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [COUNT_W-1:0] hit_cnt_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	// Read stage
	entry_t             rdata_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               rd_s1;

	// Update decisions
	logic               we;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_data;
	logic               v_set;
	logic               v_clr;
	rsp_t               rsp;

	logic               done_q;
	rsp_t               result_q;

	assign sts.scan_last = (addr_q == IDX_W'(ENTRIES - 1));

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_idx] <= wr_data;
		end
		if (ctl.rd) begin
			rdata_s1 <= mem[addr_q];
			idx_s1   <= addr_q;
		end
	end

	// Track read stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= ctl.rd;
		end
	end

	// Clear the trackers on a new request, step the scan address, flag first hit and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (ctl.load && start) begin
				addr_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (ctl.rd) begin
				addr_q <= IDX_W'(addr_q + 1'b1);
			end
			if (rd_s1) begin
				if (valid_q[idx_s1]) begin
					if (!hit_q && rdata_s1.value == req_q.value) begin
						hit_q <= 1'b1;
					end
				end else if (!free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	// Payload side of the scan trackers
	always_ff @(posedge clk) begin
		if (ctl.load && start) begin
			req_q <= request;
		end
		if (rd_s1 && valid_q[idx_s1] && !hit_q && rdata_s1.value == req_q.value) begin
			hit_idx_q <= idx_s1;
			hit_cnt_q <= rdata_s1.count;
		end
		if (rd_s1 && !valid_q[idx_s1] && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// Decide the table change and the result
	always_comb begin
		we      = 1'b0;
		wr_idx  = hit_idx_q;
		wr_data = '{value: req_q.value, count: hit_cnt_q};
		v_set   = 1'b0;
		v_clr   = 1'b0;
		rsp     = '{status: ST_FULL, slot: '0, count_after: '0};
		if (req_q.opcode == OP_ADD) begin
			if (hit_q) begin
				rsp.slot = SLOT_W'(hit_idx_q);
				if (hit_cnt_q == COUNT_MAX) begin
					rsp.status      = ST_FULL;
					rsp.count_after = COUNT_MAX;
				end else begin
					we              = 1'b1;
					wr_data.count   = COUNT_W'(hit_cnt_q + 1'b1);
					rsp.status      = ST_INC;
					rsp.count_after = wr_data.count;
				end
			end else if (free_q) begin
				we              = 1'b1;
				v_set           = 1'b1;
				wr_idx          = free_idx_q;
				wr_data.count   = COUNT_W'(1);
				rsp.status      = ST_NEW;
				rsp.slot        = SLOT_W'(free_idx_q);
				rsp.count_after = COUNT_W'(1);
			end
		end else begin
			if (!hit_q) begin
				rsp.status = ST_MISSING;
			end else if (hit_cnt_q <= COUNT_W'(1)) begin
				we         = 1'b1;
				v_clr      = 1'b1;
				wr_data    = '0;
				rsp.status = ST_REMOVED;
				rsp.slot   = SLOT_W'(hit_idx_q);
			end else begin
				we              = 1'b1;
				wr_data.count   = COUNT_W'(hit_cnt_q - 1'b1);
				rsp.status      = ST_DEC;
				rsp.slot        = SLOT_W'(hit_idx_q);
				rsp.count_after = wr_data.count;
			end
		end
		we = we && ctl.upd;
	end

	// Valid marks and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.upd;
			if (ctl.upd && v_set) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ctl.upd && v_clr) begin
				valid_q[wr_idx] <= 1'b0;
			end
		end
	end

	// Register the result for its strobe cycle; it holds until the next update
	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			result_q <= rsp;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`MCT_ASSERT_NEXT(a_upd_strobes, ctl.upd, done_q, "update did not raise the strobe")
	`MCT_ASSERT_NOW(a_strobe_source, done_q, $past(ctl.upd), "strobe without an update")
	`MCT_ASSERT_NOW(a_hit_is_valid, ctl.upd && hit_q, valid_q[hit_idx_q], "hit on a free slot")
	`MCT_ASSERT_NOW(a_no_read_on_write, we, !ctl.rd, "memory written during the scan")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import mct_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int POOL_SIZE   = 40;

	logic  clk;
	logic  arst_n;
	logic  start;
	req_t  request;
	logic  busy;
	logic  done;
	rsp_t  result;

	// Shadow copy of the slot table
	logic [VALUE_W-1:0] tbl_val  [ENTRIES];
	logic [COUNT_W-1:0] tbl_cnt  [ENTRIES];
	logic               tbl_used [ENTRIES];

	rsp_t               answers_due[$];
	logic [VALUE_W-1:0] value_pool [POOL_SIZE];
	int                 idle_pct;
	int                 errors;
	int                 quiet_cycles;

	multiset_count_table_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow table and return the answer it gives
	function automatic rsp_t apply_to_table(input req_t r);
		int   hit;
		int   free_slot;
		int   i;
		rsp_t a;
		hit = -1;
		free_slot = -1;
		a.status = ST_FULL;
		a.slot = '0;
		a.count_after = '0;
		for (i = 0; i < ENTRIES; i++) begin
			if (tbl_used[i]) begin
				if (hit < 0 && tbl_val[i] == r.value)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (r.opcode == OP_ADD) begin
			if (hit >= 0) begin
				a.slot = hit[SLOT_W-1:0];
				if (tbl_cnt[hit] == COUNT_MAX) begin
					a.status = ST_FULL;
					a.count_after = COUNT_MAX;
				end else begin
					tbl_cnt[hit] = tbl_cnt[hit] + 1'b1;
					a.status = ST_INC;
					a.count_after = tbl_cnt[hit];
				end
			end else if (free_slot >= 0) begin
				tbl_used[free_slot] = 1'b1;
				tbl_val[free_slot] = r.value;
				tbl_cnt[free_slot] = COUNT_W'(1);
				a.status = ST_NEW;
				a.slot = free_slot[SLOT_W-1:0];
				a.count_after = COUNT_W'(1);
			end
		end else begin
			if (hit < 0) begin
				a.status = ST_MISSING;
			end else if (tbl_cnt[hit] <= 1) begin
				tbl_used[hit] = 1'b0;
				tbl_val[hit] = '0;
				tbl_cnt[hit] = '0;
				a.status = ST_REMOVED;
				a.slot = hit[SLOT_W-1:0];
			end else begin
				tbl_cnt[hit] = tbl_cnt[hit] - 1'b1;
				a.status = ST_DEC;
				a.slot = hit[SLOT_W-1:0];
				a.count_after = tbl_cnt[hit];
			end
		end
		return a;
	endfunction

	// Offer one request, wait for it to be taken, then maybe idle for a while
	task automatic send_request(input logic op, input logic [VALUE_W-1:0] v);
		req_t r;
		r.opcode = op;
		r.value = v;
		start <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (busy);
		answers_due.push_back(apply_to_table(r));
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 60)) @(negedge clk);
		end
	endtask

	// Remove copies until every slot of the table is free
	task automatic drain_table();
		int i;
		for (i = 0; i < ENTRIES; i++)
			while (tbl_used[i])
				send_request(OP_REMOVE, tbl_val[i]);
	endtask

	// Insert, increment, decrement, remove and miss, with the extreme values
	task automatic test_basic_ops();
		send_request(OP_ADD, 8'h00);
		send_request(OP_ADD, 8'h00);
		send_request(OP_ADD, 8'hFF);
		send_request(OP_ADD, 8'h55);
		send_request(OP_REMOVE, 8'hFF);
		send_request(OP_ADD, 8'hAA);
		send_request(OP_REMOVE, 8'h33);
		send_request(OP_REMOVE, 8'h00);
		send_request(OP_REMOVE, 8'h00);
		send_request(OP_REMOVE, 8'h00);
		send_request(OP_REMOVE, 8'h55);
		send_request(OP_REMOVE, 8'hAA);
	endtask

	// Fill every slot, add to a full table, reuse a freed hole, then empty it
	task automatic test_full_table();
		int i;
		for (i = 0; i < ENTRIES; i++)
			send_request(OP_ADD, VALUE_W'(i * 8 + 7));
		send_request(OP_ADD, 8'h00);
		send_request(OP_ADD, 8'h07);
		send_request(OP_REMOVE, VALUE_W'(13 * 8 + 7));
		send_request(OP_ADD, 8'h00);
		send_request(OP_ADD, 8'h01);
		drain_table();
	endtask

	// Random adds and removes, mostly over a small pool so slots get hit
	task automatic test_random_mix(input int pct, input int n);
		int                 k;
		logic               op;
		logic [VALUE_W-1:0] v;
		idle_pct = pct;
		for (k = 0; k < POOL_SIZE; k++)
			value_pool[k] = VALUE_W'($urandom_range(255));
		for (k = 0; k < n; k++) begin
			op = ($urandom_range(99) < 55) ? OP_ADD : OP_REMOVE;
			if ($urandom_range(99) < 80)
				v = value_pool[$urandom_range(POOL_SIZE - 1)];
			else
				v = VALUE_W'($urandom_range(255));
			send_request(op, v);
		end
	endtask

	// Stack many copies of one value, then remove them all and one more
	task automatic test_deep_count();
		int                 k;
		logic [VALUE_W-1:0] v;
		idle_pct = 0;
		drain_table();
		v = VALUE_W'($urandom_range(255));
		for (k = 0; k < 40; k++)
			send_request(OP_ADD, v);
		for (k = 0; k < 41; k++)
			send_request(OP_REMOVE, v);
	endtask

	// Compare each strobed result with the oldest answer due
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result status %0d slot %0d count %0d",
					$time, result.status, result.slot, result.count_after);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, result.status);
					errors++;
				end
				if (result.slot !== want.slot) begin
					$display("%0t: slot expected %0d, got %0d",
						$time, want.slot, result.slot);
					errors++;
				end
				if (result.count_after !== want.count_after) begin
					$display("%0t: count_after expected %0d, got %0d",
						$time, want.count_after, result.count_after);
					errors++;
				end
			end
		end
	end

	// Abort when nothing has been accepted or finished for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL multiset_count_table_top");
				$finish;
			end
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		idle_pct = 0;
		errors = 0;
		quiet_cycles = 0;
		for (i = 0; i < ENTRIES; i++) begin
			tbl_val[i] = '0;
			tbl_cnt[i] = '0;
			tbl_used[i] = 1'b0;
		end
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_ops();
		test_full_table();
		test_random_mix(7, 65);
		test_random_mix(55, 65);
		test_random_mix(0, 65);
		test_deep_count();
		start <= 1'b0;

		// Drain outstanding answers, then let the sequencer settle
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("PASS multiset_count_table_top");
		else
			$display("FAIL multiset_count_table_top");
		$finish;
	end

endmodule
